// ===== rtl/vsts_pkg.sv =====
// Shared types, codes and the control-store contents of the volume store sampler.
`default_nettype none

package vsts_pkg;

    // Item mode codes.
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CHK_RD = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLP_RD = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FILL   = 3'd4;

    // Configuration port.
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIZE_Z = 2'd2;
    localparam logic [CFG_W-1:0]     CFG_SIZE_RESET = 6'd32;

    // Output value selection.
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_ZERO   = 2'd0;
    localparam t_sel SEL_READ   = 2'd1;
    localparam t_sel SEL_SAMPLE = 2'd2;

    // Jump conditions.
    typedef logic [1:0] t_cond;
    localparam t_cond COND_NONE   = 2'd0;
    localparam t_cond COND_ALWAYS = 2'd1;
    localparam t_cond COND_CORNER = 2'd2;
    localparam t_cond COND_SWEEP  = 2'd3;

    // Microprogram addresses.
    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] t_upc;
    localparam t_upc UPC_WRITE    = 4'd0;
    localparam t_upc UPC_READ     = 4'd1;
    localparam t_upc UPC_RD_EMIT  = 4'd2;
    localparam t_upc UPC_SAMPLE   = 4'd3;
    localparam t_upc UPC_DRAIN0   = 4'd4;
    localparam t_upc UPC_DRAIN1   = 4'd5;
    localparam t_upc UPC_DRAIN2   = 4'd6;
    localparam t_upc UPC_SMP_EMIT = 4'd7;
    localparam t_upc UPC_FILL     = 4'd8;
    localparam t_upc UPC_EMIT     = 4'd9;

    typedef struct packed {
        logic  issue;   // read the store at the current corner address
        logic  blend;   // the read feeds the weighting pipeline
        logic  wr;      // write the item's sample at its cell if in range
        logic  fill;    // write the item's sample at the sweep address
        logic  emit;    // hand the result to the output register
        t_sel  sel;
        t_cond cond;
        t_upc  target;
    } t_uop;

    localparam t_uop UOP_NOP = '{issue: 1'b0, blend: 1'b0, wr: 1'b0, fill: 1'b0,
                                 emit: 1'b0, sel: SEL_ZERO, cond: COND_NONE,
                                 target: UPC_WRITE};

    function automatic t_uop uop_rom(input t_upc pc);
        t_uop u;
        u = UOP_NOP;
        case (pc)
            UPC_WRITE: begin
                u.wr     = 1'b1;
                u.cond   = COND_ALWAYS;
                u.target = UPC_EMIT;
            end
            UPC_READ: begin
                u.issue = 1'b1;
            end
            UPC_RD_EMIT: begin
                u.emit = 1'b1;
                u.sel  = SEL_READ;
            end
            UPC_SAMPLE: begin
                u.issue  = 1'b1;
                u.blend  = 1'b1;
                u.cond   = COND_CORNER;
                u.target = UPC_SAMPLE;
            end
            UPC_DRAIN0, UPC_DRAIN1, UPC_DRAIN2: begin
                u = UOP_NOP;
            end
            UPC_SMP_EMIT: begin
                u.emit = 1'b1;
                u.sel  = SEL_SAMPLE;
            end
            UPC_FILL: begin
                u.fill   = 1'b1;
                u.cond   = COND_SWEEP;
                u.target = UPC_FILL;
            end
            default: begin
                u.emit = 1'b1;
                u.sel  = SEL_ZERO;
            end
        endcase
        return u;
    endfunction

    function automatic t_upc mode_entry(input logic [MODE_W-1:0] mode);
        t_upc e;
        case (mode)
            MODE_WRITE:  e = UPC_WRITE;
            MODE_CHK_RD: e = UPC_READ;
            MODE_CLP_RD: e = UPC_READ;
            MODE_SAMPLE: e = UPC_SAMPLE;
            MODE_FILL:   e = UPC_FILL;
            default:     e = UPC_EMIT;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vsts_in_if.sv =====
// Input channel of the volume store sampler: mode, position and sample.
`default_nettype none

interface vsts_in_if #(
    parameter int POS_W    = 13,
    parameter int SAMPLE_W = 16
);
    import vsts_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic [POS_W-1:0]           x_pos;
    logic [POS_W-1:0]           y_pos;
    logic [POS_W-1:0]           z_pos;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source(output valid, mode, x_pos, y_pos, z_pos, sample_value, input ready);
    modport sink(input valid, mode, x_pos, y_pos, z_pos, sample_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/vsts_out_if.sv =====
// Output channel of the volume store sampler: result value and status.
`default_nettype none

interface vsts_out_if #(
    parameter int SAMPLE_W = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] result_value;
    logic                       status;

    modport source(output valid, result_value, status, input ready);
    modport sink(input valid, result_value, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/volume_store_trilinear_sampler_unit.sv =====
// Volume store with trilinear sampler: microcoded control over a single-port sample store.
//
// The block keeps a cube of (1 << DIM_BITS)^3 signed samples in one single-port memory, with
// cell (x, y, z) at address {z, y, x}; the three size registers only bound the box that is
// checked or clamped against (zero acts as 1, anything above the axis length as the full
// axis). Each input transfer carries a mode and produces exactly one output transfer.
// A microprogram in a small read-only control store sequences the datapath: one control word
// per step, a step counter, and conditional jumps that loop over the eight corners of a
// trilinear sample or over every cell of a fill. A trilinear sample makes eight corner reads,
// one per cycle through the single memory port, then lets the weight, multiply and accumulate
// stages drain; a fill writes one cell per cycle through the same port. Results sit in an
// output register, so the next input transfer is taken as soon as the current result has been
// loaded there, even while it still waits for the sink. Trilinear samples are exact: the eight
// products of sample and weight are summed in full width and rounded to nearest, ties upward.
// Configuration writes must only be issued while the block is idle. The store has no reset;
// cells must be written or filled before they are read.
`default_nettype none

module volume_store_trilinear_sampler_unit #(
    parameter int DIM_BITS    = 5,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [vsts_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [vsts_pkg::CFG_W-1:0]       i_cfg_data,
    vsts_in_if.sink                               i_in_ch,
    vsts_out_if.source                            o_out_ch
);
    import vsts_pkg::*;

    localparam int POS_W      = DIM_BITS + FRAC_BITS;
    localparam int EXT_W      = DIM_BITS + 1;
    localparam int CMP_W      = (CFG_W > EXT_W) ? CFG_W : EXT_W;
    localparam int AXIS_CELLS = 1 << DIM_BITS;
    localparam int ADDR_W     = 3 * DIM_BITS;
    localparam int CELLS      = 1 << ADDR_W;
    localparam int W1_W       = FRAC_BITS + 1;
    localparam int WXY_W      = 2 * FRAC_BITS + 1;
    localparam int W3_W       = 3 * FRAC_BITS + 1;
    localparam int PROD_W     = SAMPLE_BITS + W3_W + 1;
    localparam int ACC_W      = PROD_W + 3;
    localparam int RND_SH     = 3 * FRAC_BITS;

    localparam logic [W1_W-1:0]  W_ONE    = W1_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (RND_SH - 1);

    // Extent seen by the datapath for one size register.
    function automatic logic [EXT_W-1:0] f_extent(input logic [CFG_W-1:0] cfg_v);
        logic [CMP_W-1:0] v;
        logic [EXT_W-1:0] e;
        v = CMP_W'(cfg_v);
        if (v == '0) begin
            e = EXT_W'(1);
        end else if (v > CMP_W'(AXIS_CELLS)) begin
            e = EXT_W'(AXIS_CELLS);
        end else begin
            e = EXT_W'(v);
        end
        return e;
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0] r_size [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size[0] <= CFG_SIZE_RESET;
            r_size[1] <= CFG_SIZE_RESET;
            r_size[2] <= CFG_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_SIZE_X: r_size[0] <= i_cfg_data;
                CFG_IDX_SIZE_Y: r_size[1] <= i_cfg_data;
                CFG_IDX_SIZE_Z: r_size[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Per-axis corner coordinates of the incoming item, clamped to the extents.
    logic [POS_W-1:0]     pos     [3];
    logic [DIM_BITS-1:0]  lo_c    [3];
    logic [DIM_BITS-1:0]  hi_c    [3];
    logic [FRAC_BITS-1:0] frac_c  [3];
    logic [2:0]           in_axis;

    assign pos[0] = i_in_ch.x_pos;
    assign pos[1] = i_in_ch.y_pos;
    assign pos[2] = i_in_ch.z_pos;

    always_comb begin
        logic [EXT_W-1:0] ext;
        logic [EXT_W-1:0] ext_m1;
        logic [EXT_W-1:0] lo_raw;
        logic [EXT_W-1:0] hi_raw;
        for (int a = 0; a < 3; a++) begin
            ext        = f_extent(r_size[a]);
            ext_m1     = ext - EXT_W'(1);
            frac_c[a]  = pos[a][FRAC_BITS-1:0];
            lo_raw     = EXT_W'(pos[a][POS_W-1:FRAC_BITS]);
            hi_raw     = lo_raw + EXT_W'(frac_c[a] != '0);
            in_axis[a] = lo_raw < ext;
            lo_c[a]    = in_axis[a] ? lo_raw[DIM_BITS-1:0] : ext_m1[DIM_BITS-1:0];
            hi_c[a]    = (hi_raw < ext) ? hi_raw[DIM_BITS-1:0] : ext_m1[DIM_BITS-1:0];
        end
    end

    // Sequencer state.
    logic                   r_busy;
    t_upc                   r_pc;
    logic [2:0]             r_corner;
    logic [ADDR_W-1:0]      r_sweep;
    logic                   in_fire;
    t_uop                   uop;
    logic                   cond_true;
    logic                   emit_fire;

    // Item registers.
    logic [DIM_BITS-1:0]    r_lo   [3];
    logic [DIM_BITS-1:0]    r_hi   [3];
    logic [FRAC_BITS-1:0]   r_frac [3];
    logic                   r_inside;
    logic                   r_chk;
    logic [SAMPLE_BITS-1:0] r_sample;

    assign i_in_ch.ready = !r_busy;
    assign in_fire       = i_in_ch.valid && !r_busy;
    assign uop           = r_busy ? uop_rom(r_pc) : UOP_NOP;

    always_comb begin
        case (uop.cond)
            COND_ALWAYS: cond_true = 1'b1;
            COND_CORNER: cond_true = r_corner != 3'b111;
            COND_SWEEP:  cond_true = r_sweep != {ADDR_W{1'b1}};
            default:     cond_true = 1'b0;
        endcase
    end

    // Output register.
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_value;
    logic                   r_out_status;

    assign emit_fire = uop.emit && (!r_out_valid || o_out_ch.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= UPC_WRITE;
        end else if (in_fire) begin
            r_busy <= 1'b1;
            r_pc   <= mode_entry(i_in_ch.mode);
        end else if (r_busy) begin
            if (uop.emit) begin
                if (emit_fire) begin
                    r_busy <= 1'b0;
                end
            end else if (cond_true) begin
                r_pc <= uop.target;
            end else begin
                r_pc <= r_pc + t_upc'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= '0;
            r_sweep  <= '0;
        end else if (in_fire) begin
            r_corner <= '0;
            r_sweep  <= '0;
        end else begin
            if (uop.issue) begin
                r_corner <= r_corner + 3'd1;
            end
            if (uop.fill) begin
                r_sweep <= r_sweep + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a]   <= lo_c[a];
                r_hi[a]   <= hi_c[a];
                r_frac[a] <= frac_c[a];
            end
            r_inside <= &in_axis;
            r_chk    <= (i_in_ch.mode == MODE_WRITE) || (i_in_ch.mode == MODE_CHK_RD);
            r_sample <= i_in_ch.sample_value;
        end
    end

    // Sample store: one port, read data registered.
    logic [SAMPLE_BITS-1:0] r_mem [CELLS];
    logic [SAMPLE_BITS-1:0] r_rd;
    logic [ADDR_W-1:0]      corner_addr;
    logic [ADDR_W-1:0]      mem_addr;
    logic                   mem_we;

    assign corner_addr = {r_corner[2] ? r_hi[2] : r_lo[2],
                          r_corner[1] ? r_hi[1] : r_lo[1],
                          r_corner[0] ? r_hi[0] : r_lo[0]};
    assign mem_addr    = uop.fill ? r_sweep : corner_addr;
    assign mem_we      = uop.fill || (uop.wr && r_inside);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= r_sample;
        end
        if (uop.issue) begin
            r_rd <= r_mem[mem_addr];
        end
    end

    // Weighting pipeline: x*y weight, then z weight, then sample product, then accumulate.
    logic [W1_W-1:0]          wx;
    logic [W1_W-1:0]          wy;
    logic [W1_W-1:0]          wz;
    logic [WXY_W-1:0]         wxy;
    logic [W3_W-1:0]          w3;
    logic signed [PROD_W-1:0] v_ext;
    logic signed [PROD_W-1:0] w_ext;
    logic [WXY_W-1:0]         r_wxy;
    logic                     r_zsel;
    logic [W3_W-1:0]          r_w3;
    logic [SAMPLE_BITS-1:0]   r_v;
    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]         r_acc;
    logic                     r_pv1;
    logic                     r_pv2;
    logic                     r_pv3;

    assign wx    = r_corner[0] ? W1_W'(r_frac[0]) : W_ONE - W1_W'(r_frac[0]);
    assign wy    = r_corner[1] ? W1_W'(r_frac[1]) : W_ONE - W1_W'(r_frac[1]);
    assign wz    = r_zsel      ? W1_W'(r_frac[2]) : W_ONE - W1_W'(r_frac[2]);
    assign wxy   = WXY_W'(wx) * WXY_W'(wy);
    assign w3    = W3_W'(r_wxy) * W3_W'(wz);
    assign v_ext = {{(PROD_W - SAMPLE_BITS){r_v[SAMPLE_BITS-1]}}, r_v};
    assign w_ext = {{(PROD_W - W3_W){1'b0}}, r_w3};

    always_ff @(posedge i_clk) begin
        if (uop.issue) begin
            r_wxy  <= wxy;
            r_zsel <= r_corner[2];
        end
        r_w3   <= w3;
        r_v    <= r_rd;
        r_prod <= v_ext * w_ext;
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_acc <= ACC_HALF;
        end else if (r_pv3) begin
            r_acc <= r_acc + {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv1 <= 1'b0;
            r_pv2 <= 1'b0;
            r_pv3 <= 1'b0;
        end else begin
            r_pv1 <= uop.issue && uop.blend;
            r_pv2 <= r_pv1;
            r_pv3 <= r_pv2;
        end
    end

    // Result selection and output register.
    logic [SAMPLE_BITS-1:0] emit_value;
    logic                   emit_status;

    assign emit_status = r_chk && !r_inside;

    always_comb begin
        case (uop.sel)
            SEL_READ:   emit_value = emit_status ? '0 : r_rd;
            SEL_SAMPLE: emit_value = r_acc[RND_SH +: SAMPLE_BITS];
            default:    emit_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_value  <= emit_value;
            r_out_status <= emit_status;
        end
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.result_value = r_out_value;
    assign o_out_ch.status       = r_out_status;

    // A write step never touches the store for a cell outside the extents.
    a_no_stray_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (uop.fill || r_inside))
        else $error("store written outside the extents");

    // Products reach the accumulator only while a sample is still in progress.
    a_accum_in_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv3 |-> r_busy)
        else $error("accumulation after the item finished");

    // Loading the output register ends the item and frees the input side.
    a_emit_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire |=> (!r_busy && r_out_valid))
        else $error("item not retired after its result was loaded");

endmodule

`default_nettype wire
